[src/ksl_pkg.sv]
// ----------------------------------------------------------------------------
// ksl_pkg
// shared types and codes for the knock sequence lock
// ----------------------------------------------------------------------------
package ksl_pkg;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KNOCK_THR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_THR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EXP_LEN     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EXP_CODE    = 3'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_KNOCK  = 2'd1;
  localparam logic [1:0] EV_SOLVED = 2'd2;
  localparam logic [1:0] EV_FAILED = 2'd3;

  typedef struct packed {
    logic [11:0] knock_thr;
    logic [11:0] release_thr;
    logic [15:0] debounce_ms;
    logic [15:0] timeout_ms;
    logic [4:0]  exp_len;
    logic [31:0] exp_code;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  sensor;
    logic [11:0] raw;
    logic [31:0] now_ms;
    logic        enabled;
  } item_t;

endpackage

[src/ksl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ksl_cfg_regs
// configuration register file, written one word at a time
// ----------------------------------------------------------------------------
module ksl_cfg_regs
  import ksl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_KNOCK_THR:   cfg_nxt.knock_thr   = cfg_data[11:0];
        REG_RELEASE_THR: cfg_nxt.release_thr = cfg_data[11:0];
        REG_DEBOUNCE:    cfg_nxt.debounce_ms = cfg_data[15:0];
        REG_TIMEOUT:     cfg_nxt.timeout_ms  = cfg_data[15:0];
        REG_EXP_LEN:     cfg_nxt.exp_len     = cfg_data[4:0];
        REG_EXP_CODE:    cfg_nxt.exp_code    = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knock_thr   <= 12'd2000;
      cfg_r.release_thr <= 12'd1000;
      cfg_r.debounce_ms <= 16'd150;
      cfg_r.timeout_ms  <= 16'd2000;
      cfg_r.exp_len     <= 5'd4;
      cfg_r.exp_code    <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[src/ksl_in_reg.sv]
// ----------------------------------------------------------------------------
// ksl_in_reg
// input register, refills in the cycle the held word is consumed
// ----------------------------------------------------------------------------
module ksl_in_reg
  import ksl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_take,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[src/ksl_core.sv]
// ----------------------------------------------------------------------------
// ksl_core
// latches, debounce, sequence store, timeout judge and result register
// ----------------------------------------------------------------------------
module ksl_core
  import ksl_pkg::*;
#(
  parameter int SENSORS      = 4,
  parameter int MAX_SEQUENCE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_valid,
  output logic       item_take,
  input  item_t      item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [1:0] out_knock_sensor,
  output logic [4:0] out_sequence_count
);

  localparam logic [4:0] SEQ_CAP = 5'(MAX_SEQUENCE);

  logic [SENSORS-1:0] latch_r;
  logic [SENSORS-1:0] latch_nxt;
  logic [31:0]        lkt_r [SENSORS];
  logic [1:0]         seq_r [MAX_SEQUENCE];
  logic [4:0]         len_r;
  logic [4:0]         len_nxt;
  logic [31:0]        act_r;
  logic [31:0]        act_nxt;

  logic               out_valid_r;
  logic [1:0]         ev_r;
  logic [1:0]         ev_nxt;
  logic [1:0]         who_r;
  logic [1:0]         who_nxt;
  logic [4:0]         cnt_r;

  logic [SENSORS-1:0] sel;
  logic               in_range;
  logic               latch_cur;
  logic [31:0]        lkt_cur;
  logic [31:0]        gap;
  logic [31:0]        idle;
  logic               is_sample;
  logic               rise;
  logic               accept;
  logic               release_hit;
  logic               append;
  logic               judge;
  logic               match;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign is_sample = (item.cmd == CMD_SAMPLE);

  always_comb begin
    latch_cur = 1'b0;
    lkt_cur   = '0;
    for (int s = 0; s < SENSORS; s++) begin
      sel[s] = (item.sensor == 2'(s));
      if (sel[s]) begin
        latch_cur = latch_r[s];
        lkt_cur   = lkt_r[s];
      end
    end
  end

  assign in_range    = |sel;
  assign gap         = item.now_ms - lkt_cur;
  assign idle        = item.now_ms - act_r;
  assign rise        = is_sample && in_range && !latch_cur && (item.raw >= cfg.knock_thr);
  assign accept      = rise && item.enabled && (gap >= {16'b0, cfg.debounce_ms});
  assign release_hit = is_sample && in_range && latch_cur && (item.raw < cfg.release_thr);
  assign append      = accept && (len_r < SEQ_CAP);
  assign judge       = !is_sample && (len_r != 5'd0) && (idle >= {16'b0, cfg.timeout_ms});

  // parallel compare of held entries against the code
  always_comb begin
    match = (len_r == cfg.exp_len);
    for (int k = 0; k < MAX_SEQUENCE; k++) begin
      if ((5'(k) < len_r) && (seq_r[k] != cfg.exp_code[2*k +: 2])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    latch_nxt = latch_r;
    len_nxt   = len_r;
    act_nxt   = act_r;
    ev_nxt    = EV_NONE;
    who_nxt   = 2'd0;
    if (rise) begin
      latch_nxt = latch_r | sel;
    end else if (release_hit) begin
      latch_nxt = latch_r & ~sel;
    end
    if (accept) begin
      act_nxt = item.now_ms;
      ev_nxt  = EV_KNOCK;
      who_nxt = item.sensor;
      if (append) begin
        len_nxt = len_r + 5'd1;
      end
    end
    if (judge) begin
      ev_nxt  = match ? EV_SOLVED : EV_FAILED;
      len_nxt = 5'd0;
      act_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= '0;
      len_r       <= 5'd0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SENSORS; s++) begin
        lkt_r[s] <= '0;
      end
    end else begin
      if (item_take) begin
        latch_r <= latch_nxt;
        len_r   <= len_nxt;
        act_r   <= act_nxt;
        for (int s = 0; s < SENSORS; s++) begin
          if (accept && sel[s]) begin
            lkt_r[s] <= item.now_ms;
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sequence entries, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_SEQUENCE; k++) begin
      if (item_take && append && (len_r == 5'(k))) begin
        seq_r[k] <= item.sensor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      ev_r  <= ev_nxt;
      who_r <= who_nxt;
      cnt_r <= len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = ev_r;
  assign out_knock_sensor   = who_r;
  assign out_sequence_count = cnt_r;

endmodule

[src/knock_sequence_lock.sv]
// ----------------------------------------------------------------------------
// knock_sequence_lock
// piezo knock detector with hysteresis, debounce and a code sequence lock
// ----------------------------------------------------------------------------
//
//   channel  handshake           payload
//   in       in_valid/in_ready   cmd, sensor, raw, now_ms, enabled
//   out      out_valid/out_ready event_res, knock_sensor, sequence_count
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// one item per cycle while the output is not held; each item gives one word,
// after one pass through the core logic between the input and result registers
// synchronous reset clears latches, knock times, sequence length, activity
// time and restores register defaults; sequence entries are not cleared
// with out_ready low the result holds and the input register takes one more
// ----------------------------------------------------------------------------
module knock_sequence_lock
  import ksl_pkg::*;
#(
  parameter int SENSORS      = 4,
  parameter int MAX_SEQUENCE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [1:0]         in_sensor,
  input  logic [11:0]        in_raw,
  input  logic [31:0]        in_now_ms,
  input  logic               in_enabled,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_res,
  output logic [1:0]         out_knock_sensor,
  output logic [4:0]         out_sequence_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;

  assign in_item.cmd     = in_cmd;
  assign in_item.sensor  = in_sensor;
  assign in_item.raw     = in_raw;
  assign in_item.now_ms  = in_now_ms;
  assign in_item.enabled = in_enabled;

  ksl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ksl_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  ksl_core #(
    .SENSORS      (SENSORS),
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .item_valid         (item_valid),
    .item_take          (item_take),
    .item               (item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_knock_sensor   (out_knock_sensor),
    .out_sequence_count (out_sequence_count)
  );

endmodule

[tb/tb_knock_sequence_lock.sv]
// ----------------------------------------------------------------------------
// tb_knock_sequence_lock
// self-checking bench: a directed table of knocks, releases and checks run
// on the reset settings, then random phases of knock trains and noise under
// several register settings, random gaps on both handshakes but in the last;
// each result word is held to its typed row or a behavioral copy of the lock
// ----------------------------------------------------------------------------
module tb_knock_sequence_lock;
  timeunit 1ns;
  timeprecision 1ps;
  import ksl_pkg::*;

  localparam int NUM_SENSORS   = 4;
  localparam int SEQ_DEPTH     = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 105;
  localparam int TAIL_CYCLES   = 6;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] who;
    logic [4:0] count;
  } lock_result_t;

  typedef struct packed {
    item_t        it;
    logic         typed;
    lock_result_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic [1:0]         in_sensor;
  logic [11:0]        in_raw;
  logic [31:0]        in_now_ms;
  logic               in_enabled;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_event_res;
  logic [1:0]         out_knock_sensor;
  logic [4:0]         out_sequence_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  knock_sequence_lock dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_sensor         (in_sensor),
    .in_raw            (in_raw),
    .in_now_ms         (in_now_ms),
    .in_enabled        (in_enabled),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_knock_sensor  (out_knock_sensor),
    .out_sequence_count(out_sequence_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // lock copy
  cfg_t        cfg_m;
  logic        latch_q      [NUM_SENSORS];
  logic [31:0] knock_time_q [NUM_SENSORS];
  logic [1:0]  seq_q        [SEQ_DEPTH];
  logic [4:0]  seq_len_q;
  logic [31:0] activity_q;

  lock_result_t expected_words [$];
  lock_result_t got_word;
  lock_result_t want_word;
  dir_row_t     dir_table [$];
  int           mismatch_count;
  int           words_sent;
  bit           idle_on;
  logic [31:0]  clock_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_knock_sequence_lock failed");
    $finish;
  end

  function automatic lock_result_t knock_lock_predict(item_t it);
    lock_result_t r;
    logic [31:0]  gap;
    logic         match;
    int           k;
    r = '0;
    if (it.cmd == CMD_SAMPLE) begin
      if (int'(it.sensor) < NUM_SENSORS) begin
        if (!latch_q[it.sensor] && it.raw >= cfg_m.knock_thr) begin
          latch_q[it.sensor] = 1'b1;
          gap = it.now_ms - knock_time_q[it.sensor];
          if (it.enabled && gap >= {16'd0, cfg_m.debounce_ms}) begin
            knock_time_q[it.sensor] = it.now_ms;
            if (int'(seq_len_q) < SEQ_DEPTH) begin
              seq_q[seq_len_q[3:0]] = it.sensor;
              seq_len_q = seq_len_q + 5'd1;
            end
            activity_q = it.now_ms;
            r.ev = EV_KNOCK;
            r.who = it.sensor;
          end
        end else if (latch_q[it.sensor] && it.raw < cfg_m.release_thr) begin
          latch_q[it.sensor] = 1'b0;
        end
      end
    end else begin
      gap = it.now_ms - activity_q;
      if (seq_len_q != 5'd0 && gap >= {16'd0, cfg_m.timeout_ms}) begin
        match = (seq_len_q == cfg_m.exp_len);
        for (k = 0; k < SEQ_DEPTH; k++) begin
          if (k < int'(seq_len_q) && seq_q[k] != cfg_m.exp_code[2*k +: 2]) begin
            match = 1'b0;
          end
        end
        r.ev = match ? EV_SOLVED : EV_FAILED;
        seq_len_q = 5'd0;
        activity_q = 32'd0;
      end
    end
    r.count = seq_len_q;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic cmd, logic [1:0] sensor, logic [11:0] raw,
                                      logic [31:0] now, logic en, logic typed,
                                      logic [1:0] ev, logic [1:0] who, logic [4:0] cnt);
    dir_row_t row;
    row.it.cmd     = cmd;
    row.it.sensor  = sensor;
    row.it.raw     = raw;
    row.it.now_ms  = now;
    row.it.enabled = en;
    row.typed      = typed;
    row.want.ev    = ev;
    row.want.who   = who;
    row.want.count = cnt;
    return row;
  endfunction

  function automatic cfg_t pick_settings(int phase);
    cfg_t c;
    c.knock_thr   = 12'($urandom_range(1, 4095));
    c.release_thr = 12'($urandom_range(1, c.knock_thr));
    c.debounce_ms = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 20))
                                               : 16'($urandom_range(0, 400));
    c.timeout_ms  = 16'($urandom_range(0, 3000));
    c.exp_len     = 5'($urandom_range(0, 16));
    c.exp_code    = $urandom;
    case (phase)
      0: begin
        c = '{12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 5'd16, 32'hFFFF_FFFF};
      end
      1: begin
        c = '0;
      end
      2: begin
        c.exp_len = 5'($urandom_range(17, 31));
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  task automatic push_item(item_t it, logic typed, lock_result_t want);
    lock_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_cmd     <= it.cmd;
    in_sensor  <= it.sensor;
    in_raw     <= it.raw;
    in_now_ms  <= it.now_ms;
    in_enabled <= it.enabled;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = knock_lock_predict(it);
    expected_words.push_back(typed ? want : r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KNOCK_THR:   cfg_m.knock_thr   = data[11:0];
      REG_RELEASE_THR: cfg_m.release_thr = data[11:0];
      REG_DEBOUNCE:    cfg_m.debounce_ms = data[15:0];
      REG_TIMEOUT:     cfg_m.timeout_ms  = data[15:0];
      REG_EXP_LEN:     cfg_m.exp_len     = data[4:0];
      REG_EXP_CODE:    cfg_m.exp_code    = data;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(cfg_t c, bit spare);
    write_reg(REG_KNOCK_THR,   {20'd0, c.knock_thr});
    write_reg(REG_RELEASE_THR, {20'd0, c.release_thr});
    write_reg(REG_DEBOUNCE,    {16'd0, c.debounce_ms});
    write_reg(REG_TIMEOUT,     {16'd0, c.timeout_ms});
    write_reg(REG_EXP_LEN,     {27'd0, c.exp_len});
    write_reg(REG_EXP_CODE,    c.exp_code);
    if (spare) begin
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // knocks on chosen sensors, each followed by a release, then a timeout check
  task automatic knock_train();
    item_t        it;
    lock_result_t none;
    logic         use_code;
    logic [1:0]   s;
    int           len;
    none = '0;
    use_code = ($urandom_range(0, 2) == 0);
    len = use_code ? ((cfg_m.exp_len > 5'd18) ? 18 : int'(cfg_m.exp_len))
                   : $urandom_range(0, 18);
    for (int k = 0; k < len; k++) begin
      s = (use_code && k < SEQ_DEPTH) ? cfg_m.exp_code[2*k +: 2] : 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        clock_ms += $urandom_range(0, cfg_m.debounce_ms);
      end else begin
        clock_ms += cfg_m.debounce_ms + $urandom_range(0, 40);
      end
      it.cmd     = CMD_SAMPLE;
      it.sensor  = s;
      it.raw     = 12'($urandom_range(4095, cfg_m.knock_thr));
      it.now_ms  = clock_ms;
      it.enabled = ($urandom_range(0, 9) != 0);
      push_item(it, 1'b0, none);
      clock_ms  += $urandom_range(1, 20);
      it.raw     = (cfg_m.release_thr == 12'd0) ? 12'd0
                                                : 12'($urandom_range(0, cfg_m.release_thr - 1));
      it.now_ms  = clock_ms;
      push_item(it, 1'b0, none);
    end
    if ($urandom_range(0, 4) == 0) begin
      clock_ms += $urandom_range(0, cfg_m.timeout_ms);
    end else begin
      clock_ms += cfg_m.timeout_ms + $urandom_range(0, 30);
    end
    it.cmd     = CMD_CHECK;
    it.sensor  = 2'($urandom_range(0, 3));
    it.raw     = 12'($urandom);
    it.now_ms  = clock_ms;
    it.enabled = 1'($urandom);
    push_item(it, 1'b0, none);
  endtask

  task automatic noise_word();
    item_t        it;
    lock_result_t none;
    none       = '0;
    it.cmd     = 1'($urandom);
    it.sensor  = 2'($urandom_range(0, 3));
    it.raw     = 12'($urandom);
    it.enabled = 1'($urandom);
    it.now_ms  = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms + $urandom_range(0, 50);
    push_item(it, 1'b0, none);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word.ev    = out_event_res;
      got_word.who   = out_knock_sensor;
      got_word.count = out_sequence_count;
      if (expected_words.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected word: ev %0d sensor %0d count %0d",
                   got_word.ev, got_word.who, got_word.count);
        end
        mismatch_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.ev != want_word.ev || got_word.who != want_word.who ||
            got_word.count != want_word.count) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected ev %0d sensor %0d count %0d,",
                     want_word.ev, want_word.who, want_word.count,
                     " got ev %0d sensor %0d count %0d",
                     got_word.ev, got_word.who, got_word.count);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_SAMPLE;
    in_sensor  = 2'd0;
    in_raw     = 12'd0;
    in_now_ms  = 32'd0;
    in_enabled = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_KNOCK_THR;
    cfg_data   = 32'd0;
    idle_on    = 1'b1;
    mismatch_count = 0;
    words_sent = 0;
    clock_ms   = 32'd0;
    cfg_m      = '{12'd2000, 12'd1000, 16'd150, 16'd2000, 5'd4, 32'd0};
    for (int k = 0; k < NUM_SENSORS; k++) begin
      latch_q[k] = 1'b0;
      knock_time_q[k] = 32'd0;
    end
    for (int k = 0; k < SEQ_DEPTH; k++) seq_q[k] = 2'd0;
    seq_len_q  = 5'd0;
    activity_q = 32'd0;

    //                         cmd         s     raw       now            en
    //                         typed ev         who   cnt
    dir_table.push_back(mk_row(CMD_CHECK,  2'd0, 12'd0,    32'd0,         1'b0,
                               1'b1, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd4095, 32'd1000,      1'b1,
                               1'b1, EV_KNOCK,  2'd0, 5'd1));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd0,    32'd1010,      1'b1,
                               1'b1, EV_NONE,   2'd0, 5'd1));
    // exactly at the threshold but inside the debounce time
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd2000, 32'd1050,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd999,  32'd1100,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    // disabled crossing, then hold at release level, then release
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd1, 12'd4095, 32'd1200,      1'b0,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd1, 12'd1000, 32'd1210,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd1, 12'd4095, 32'd1215,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd1, 12'd0,    32'd1220,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd4095, 32'd1300,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd0,    32'd1310,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    // check on a recent sequence
    dir_table.push_back(mk_row(CMD_CHECK,  2'd3, 12'd4095, 32'd1400,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd4095, 32'd1500,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd0,    32'd1510,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd4095, 32'd1700,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd0, 12'd0,    32'd1710,      1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_CHECK,  2'd0, 12'd0,    32'd3700,      1'b0,
                               1'b1, EV_SOLVED, 2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd3, 12'd4095, 32'd4000,      1'b1,
                               1'b1, EV_KNOCK,  2'd3, 5'd1));
    dir_table.push_back(mk_row(CMD_CHECK,  2'd0, 12'd0,    32'hFFFF_FFFF, 1'b0,
                               1'b1, EV_FAILED, 2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd3, 12'd0,    32'hFFFF_FFFF, 1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    // knock and idle time measured across the wrap
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd3, 12'd4095, 32'd100,       1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_SAMPLE, 2'd2, 12'd4095, 32'd100,       1'b1,
                               1'b0, EV_NONE,   2'd0, 5'd0));
    dir_table.push_back(mk_row(CMD_CHECK,  2'd1, 12'd4095, 32'd50,        1'b1,
                               1'b1, EV_FAILED, 2'd0, 5'd0));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) push_item(dir_table[i].it, dir_table[i].typed, dir_table[i].want);
    in_valid <= 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != RANDOM_PHASES - 1);
      wait_drained();
      apply_settings(pick_settings(p), p == 2);
      clock_ms = $urandom;
      begin
        int start;
        start = words_sent;
        while (words_sent - start < PHASE_WORDS) begin
          if ($urandom_range(0, 9) < 7) knock_train();
          else noise_word();
        end
      end
      in_valid <= 1'b0;
    end

    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_knock_sequence_lock passed");
    end else begin
      $display("tb_knock_sequence_lock failed");
    end
    $finish;
  end

endmodule
